[hdl/bgcd_pkg.sv]
// Shared types and constants for the binary gcd block.
package bgcd_pkg;

    // Width of the operand and divisor ports
    localparam int FIELD_WIDTH = 32;

    // Default working width of the datapath
    localparam int OPERAND_WIDTH_DEF = 32;

    // Operation applied to every bit cell in one cycle
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_LOAD,
        OP_SHR_AB,
        OP_SHR_A,
        OP_SHR_B,
        OP_SUB,
        OP_SHL_A
    } cell_op_t;

    // Control broadcast from the sequencer to the cell row
    typedef struct packed {
        cell_op_t op;
        logic     swap;   // a > b during OP_SUB
    } cell_ctrl_t;

endpackage

[hdl/bgcd_cell.sv]
// One bit slice of the gcd datapath: holds one bit of a and one bit of b.
module bgcd_cell
(
    input  logic               clk,
    input  bgcd_pkg::cell_ctrl_t ctrl,
    input  logic               ld_a,
    input  logic               ld_b,
    input  logic               a_up,        // a bit of the next higher cell
    input  logic               b_up,        // b bit of the next higher cell
    input  logic               a_dn,        // a bit of the next lower cell
    input  logic               brw_ba_in,   // borrow into b - a
    input  logic               brw_ab_in,   // borrow into a - b
    output logic               a_bit,
    output logic               b_bit,
    output logic               brw_ba_out,
    output logic               brw_ab_out
);

    logic a_reg;
    logic a_next;
    logic b_reg;
    logic b_next;
    logic d_ba;
    logic d_ab;

    // Full subtractor bits for both orders
    assign d_ba       = b_reg ^ a_reg ^ brw_ba_in;
    assign brw_ba_out = (~b_reg & a_reg) | (~(b_reg ^ a_reg) & brw_ba_in);
    assign d_ab       = a_reg ^ b_reg ^ brw_ab_in;
    assign brw_ab_out = (~a_reg & b_reg) | (~(a_reg ^ b_reg) & brw_ab_in);

    // Next bit values
    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        case (ctrl.op)
            bgcd_pkg::OP_LOAD:
            begin
                a_next = ld_a;
                b_next = ld_b;
            end
            bgcd_pkg::OP_SHR_AB:
            begin
                a_next = a_up;
                b_next = b_up;
            end
            bgcd_pkg::OP_SHR_A:
            begin
                a_next = a_up;
            end
            bgcd_pkg::OP_SHR_B:
            begin
                b_next = b_up;
            end
            bgcd_pkg::OP_SUB:
            begin
                // smaller value goes to a, difference to b
                if (ctrl.swap)
                begin
                    a_next = b_reg;
                    b_next = d_ab;
                end
                else
                begin
                    b_next = d_ba;
                end
            end
            bgcd_pkg::OP_SHL_A:
            begin
                a_next = a_dn;
            end
            default:
            begin
                a_next = a_reg;
                b_next = b_reg;
            end
        endcase
    end

    // Data bits, no reset needed
    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
    end

    assign a_bit = a_reg;
    assign b_bit = b_reg;

endmodule

[hdl/binary_gcd_word.sv]
// Top level of the binary gcd block: sequencer, bit-cell row and result register.
//
//  channel  | valid      | stall      | payload
//  ---------+------------+------------+------------------------------------
//  request  | req_valid  | req_stall  | first_operand, second_operand
//  result   | rsp_valid  | rsp_stall  | divisor, bad_operand
//
// One request at a time. A zero operand goes from the load straight to the store.
// Otherwise: load, strip, make-a-odd, reduce, restore and store, t being the shared
// power of two stripped and restored; reduce runs one halving or one subtract per cycle.
// The full-width borrow ripple through the cell row sets the cycle time.
// Reset clears the control state and the result register; the cell row needs no clearing.
// req_stall stays high from acceptance until the result is stored; a stalled
// result is held while the next request is already being worked on.
module binary_gcd_word
#(
    parameter int OPERAND_WIDTH = bgcd_pkg::OPERAND_WIDTH_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  logic [bgcd_pkg::FIELD_WIDTH-1:0] first_operand,
    input  logic [bgcd_pkg::FIELD_WIDTH-1:0] second_operand,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output logic [bgcd_pkg::FIELD_WIDTH-1:0] divisor,
    output logic                             bad_operand
);

    localparam int W    = OPERAND_WIDTH;
    localparam int FW   = bgcd_pkg::FIELD_WIDTH;
    localparam int CW   = $clog2(W);
    localparam int COPY = (W < FW) ? W : FW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STRIP,
        S_ODD_A,
        S_REDUCE,
        S_RESTORE,
        S_DONE
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    logic [CW-1:0]          cnt_reg;
    logic [CW-1:0]          cnt_next;
    logic                   bad_reg;
    logic                   bad_next;
    logic                   rsp_valid_reg;
    logic                   rsp_valid_next;
    logic [FW-1:0]          divisor_reg;
    logic [FW-1:0]          divisor_next;
    logic                   bad_out_reg;
    logic                   bad_out_next;

    bgcd_pkg::cell_ctrl_t   ctrl;
    logic [W-1:0]           ld_a;
    logic [W-1:0]           ld_b;
    logic [W-1:0]           a_vec;
    logic [W-1:0]           b_vec;
    logic [W:0]             brw_ba;
    logic [W:0]             brw_ab;
    logic                   zero_in;
    logic                   b_zero;
    logic                   out_free;

    // Operands masked or zero-extended to the working width
    always_comb
    begin
        ld_a = '0;
        ld_b = '0;
        for (int i = 0; i < COPY; i++)
        begin
            ld_a[i] = first_operand[i];
            ld_b[i] = second_operand[i];
        end
    end

    assign zero_in  = (ld_a == '0) || (ld_b == '0);
    assign b_zero   = (b_vec == '0);
    assign out_free = !rsp_valid_reg || !rsp_stall;

    // Row of bit cells, bit 0 at the bottom of the borrow chain
    assign brw_ba[0] = 1'b0;
    assign brw_ab[0] = 1'b0;

    for (genvar i = 0; i < W; i++)
    begin : g_cell
        logic a_up;
        logic b_up;
        logic a_dn;

        if (i == W - 1)
        begin : g_top
            assign a_up = 1'b0;
            assign b_up = 1'b0;
        end
        else
        begin : g_mid
            assign a_up = a_vec[i+1];
            assign b_up = b_vec[i+1];
        end

        if (i == 0)
        begin : g_bot
            assign a_dn = 1'b0;
        end
        else
        begin : g_upper
            assign a_dn = a_vec[i-1];
        end

        bgcd_cell u_cell
        (
            .clk        (clk),
            .ctrl       (ctrl),
            .ld_a       (ld_a[i]),
            .ld_b       (ld_b[i]),
            .a_up       (a_up),
            .b_up       (b_up),
            .a_dn       (a_dn),
            .brw_ba_in  (brw_ba[i]),
            .brw_ab_in  (brw_ab[i]),
            .a_bit      (a_vec[i]),
            .b_bit      (b_vec[i]),
            .brw_ba_out (brw_ba[i+1]),
            .brw_ab_out (brw_ab[i+1])
        );
    end

    // Sequencer next state and cell control
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        bad_next       = bad_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        divisor_next   = divisor_reg;
        bad_out_next   = bad_out_reg;
        ctrl.op        = bgcd_pkg::OP_HOLD;
        // b - a borrows out of the top exactly when a > b
        ctrl.swap      = brw_ba[W];

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    ctrl.op  = bgcd_pkg::OP_LOAD;
                    cnt_next = '0;
                    bad_next = zero_in;
                    state_next = zero_in ? S_DONE : S_STRIP;
                end
            end
            S_STRIP:
            begin
                if (!(a_vec[0] | b_vec[0]))
                begin
                    ctrl.op  = bgcd_pkg::OP_SHR_AB;
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = S_ODD_A;
                end
            end
            S_ODD_A:
            begin
                if (!a_vec[0])
                begin
                    ctrl.op = bgcd_pkg::OP_SHR_A;
                end
                else
                begin
                    state_next = S_REDUCE;
                end
            end
            S_REDUCE:
            begin
                if (b_zero)
                begin
                    state_next = S_RESTORE;
                end
                else if (!b_vec[0])
                begin
                    ctrl.op = bgcd_pkg::OP_SHR_B;
                end
                else
                begin
                    ctrl.op = bgcd_pkg::OP_SUB;
                end
            end
            S_RESTORE:
            begin
                if (cnt_reg != '0)
                begin
                    ctrl.op  = bgcd_pkg::OP_SHL_A;
                    cnt_next = cnt_reg - 1'b1;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    bad_out_next   = bad_reg;
                    divisor_next   = '0;
                    if (!bad_reg)
                    begin
                        for (int i = 0; i < COPY; i++)
                        begin
                            divisor_next[i] = a_vec[i];
                        end
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            bad_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
            divisor_reg   <= '0;
            bad_out_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            bad_reg       <= bad_next;
            rsp_valid_reg <= rsp_valid_next;
            divisor_reg   <= divisor_next;
            bad_out_reg   <= bad_out_next;
        end
    end

    assign req_stall   = (state_reg != S_IDLE);
    assign rsp_valid   = rsp_valid_reg;
    assign divisor     = divisor_reg;
    assign bad_operand = bad_out_reg;

    // a is odd for the whole reduction
    a_odd_in_reduce: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REDUCE) |-> a_vec[0])
        else $error("a lost its odd bit during reduction");

    // odd minus odd leaves b even
    sub_gives_even: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REDUCE && !b_zero && b_vec[0]) |=> !b_vec[0])
        else $error("subtract step left b odd");

    // a flagged result carries a zero divisor
    bad_means_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && bad_operand) |-> (divisor == '0))
        else $error("bad operand result with nonzero divisor");

    // a good result is never zero
    good_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !bad_operand) |-> (divisor != '0))
        else $error("zero divisor without bad operand flag");

    // the restore count never passes the width
    cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESTORE) |-> (cnt_reg <= CW'(W - 1)))
        else $error("shift count out of range");

endmodule

[tb/sv/binary_gcd_word_test.sv]
// Testbench for binary_gcd_word: queued gcd requests, random idling, checked results.
`timescale 1ns / 1ps

module binary_gcd_word_test;

    localparam int DW             = bgcd_pkg::FIELD_WIDTH;
    localparam int OPW            = bgcd_pkg::OPERAND_WIDTH_DEF;
    localparam int RANDOM_PAIRS   = 1400;
    localparam int DRAIN_EVERY    = 250;
    localparam int SETTLE_CYCLES  = 300;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct {
        logic [DW-1:0] first;
        logic [DW-1:0] second;
        bit            drain_first;  // hold the request until all results are back
    } operand_pair_t;

    typedef struct {
        logic [DW-1:0] divisor;
        logic          bad_operand;
    } gcd_result_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          req_valid = 1'b0;
    logic          req_stall;
    logic [DW-1:0] first_operand = '0;
    logic [DW-1:0] second_operand = '0;
    logic          rsp_valid;
    logic          rsp_stall = 1'b0;
    logic [DW-1:0] divisor;
    logic          bad_operand;

    operand_pair_t operand_pairs_q[$];
    gcd_result_t   gcd_due_q[$];
    int unsigned   mismatch_count = 0;
    int unsigned   idle_cycles = 0;
    int unsigned   req_gap = 0;
    int unsigned   req_calm = 0;
    int unsigned   stall_left = 0;
    int unsigned   rsp_calm = 0;

    binary_gcd_word #(
        .OPERAND_WIDTH(OPW)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .first_operand(first_operand),
        .second_operand(second_operand),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .divisor(divisor),
        .bad_operand(bad_operand)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // gcd of the operands after masking to the working width
    function automatic gcd_result_t compute_gcd(input logic [DW-1:0] x, input logic [DW-1:0] y);
        logic [63:0] mask;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] t;
        int unsigned twos;
        gcd_result_t r;
        mask = (OPW >= 64) ? '1 : ((64'd1 << OPW) - 64'd1);
        a = {32'd0, x} & mask;
        b = {32'd0, y} & mask;
        twos = 0;
        r.divisor = '0;
        r.bad_operand = 1'b0;
        if (a == 0 || b == 0)
        begin
            r.bad_operand = 1'b1;
            return r;
        end
        // shared powers of two
        while (a[0] == 1'b0 && b[0] == 1'b0)
        begin
            a = a >> 1;
            b = b >> 1;
            twos++;
        end
        while (a[0] == 1'b0)
            a = a >> 1;
        // a stays odd; halve b to odd, subtract the smaller from the larger
        while (b != 0)
        begin
            while (b[0] == 1'b0)
                b = b >> 1;
            if (a > b)
            begin
                t = a;
                a = b;
                b = t;
            end
            b = b - a;
        end
        t = (a << twos) & mask;
        r.divisor = t[DW-1:0];
        return r;
    endfunction

    // Idle length: mostly short, a few long, and calm stretches with none
    function automatic int unsigned pick_gap(inout int unsigned calm);
        int unsigned roll;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3)
        begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (roll < 45)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what, input logic [DW-1:0] got,
                                   input logic [DW-1:0] want);
        $display("MISMATCH %s: got %h, want %h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    task automatic add_pair(input logic [DW-1:0] a, input logic [DW-1:0] b, input bit drain);
        operand_pair_t p;
        p.first = a;
        p.second = b;
        p.drain_first = drain;
        operand_pairs_q.push_back(p);
    endtask

    // Request driver: hold payload while stalled, insert gaps between requests
    always @(posedge clk or negedge rst_n)
    begin
        operand_pair_t p;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else
        begin
            if (req_valid && !req_stall)
                gcd_due_q.push_back(compute_gcd(first_operand, second_operand));
            if (!req_valid || !req_stall)
            begin
                if (req_gap > 0)
                begin
                    req_gap--;
                    req_valid <= 1'b0;
                end
                else if (operand_pairs_q.size() != 0 &&
                         !(operand_pairs_q[0].drain_first && gcd_due_q.size() != 0))
                begin
                    p = operand_pairs_q.pop_front();
                    req_valid <= 1'b1;
                    first_operand <= p.first;
                    second_operand <= p.second;
                    req_gap = pick_gap(req_calm);
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and random result stall
    always @(posedge clk or negedge rst_n)
    begin
        gcd_result_t want;
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (gcd_due_q.size() == 0)
                begin
                    report_mismatch("result with no request outstanding", divisor, '0);
                end
                else
                begin
                    want = gcd_due_q.pop_front();
                    if (divisor !== want.divisor)
                        report_mismatch("divisor", divisor, want.divisor);
                    if (bad_operand !== want.bad_operand)
                        report_mismatch("bad_operand", DW'(bad_operand), DW'(want.bad_operand));
                end
            end
            if (stall_left == 0)
                stall_left = pick_gap(rsp_calm);
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_stall <= 1'b1;
            end
            else
            begin
                rsp_stall <= 1'b0;
            end
        end
    end

    // Cycles without any handshake on either channel
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        logic [DW-1:0] a;
        logic [DW-1:0] b;
        logic [DW-1:0] g;
        int unsigned   shape;
        bit            timed_out;
        timed_out = 1'b0;

        // Directed: zero operands, extremes, equal operands, shared twos
        add_pair(32'd0, 32'd0, 1'b0);
        add_pair(32'd0, 32'd5, 1'b0);
        add_pair(32'd7, 32'd0, 1'b0);
        add_pair(32'hFFFFFFFF, 32'd0, 1'b0);
        add_pair(32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0);
        add_pair(32'd1, 32'd1, 1'b0);
        add_pair(32'd1, 32'hFFFFFFFF, 1'b0);
        add_pair(32'hFFFFFFFF, 32'd1, 1'b0);
        add_pair(32'h80000000, 32'h80000000, 1'b0);
        add_pair(32'h80000000, 32'd1, 1'b0);
        add_pair(32'h80000000, 32'hC0000000, 1'b0);
        add_pair(32'd48, 32'd18, 1'b0);
        add_pair(32'd18, 32'd48, 1'b0);
        add_pair(32'd12, 32'd12, 1'b0);
        add_pair(32'd1071, 32'd462, 1'b0);
        add_pair(32'hFFFFFFFF, 32'hFFFFFFFE, 1'b0);
        add_pair(32'hFFFFFFFE, 32'h7FFFFFFF, 1'b0);
        add_pair(32'h55555555, 32'hAAAAAAAA, 1'b0);
        add_pair(32'hAAAAAAAA, 32'h55555555, 1'b0);
        // consecutive Fibonacci numbers
        add_pair(32'd2971215073, 32'd1836311903, 1'b1);
        add_pair(32'd1836311903, 32'd2971215073, 1'b0);

        // Random mix, mostly nonzero pairs with structure
        for (int i = 0; i < RANDOM_PAIRS; i++)
        begin
            shape = $urandom_range(0, 99);
            if (shape < 45)
            begin
                a = $urandom;
                b = $urandom;
            end
            else if (shape < 65)
            begin
                // shared factor, often with shared twos
                g = $urandom_range(1, 65535);
                g = g << $urandom_range(0, 15);
                a = g * $urandom_range(1, 32'hFFFFFFFF / g);
                b = g * $urandom_range(1, 32'hFFFFFFFF / g);
            end
            else if (shape < 75)
            begin
                a = $urandom << $urandom_range(0, 31);
                b = $urandom << $urandom_range(0, 31);
            end
            else if (shape < 85)
            begin
                a = $urandom >> $urandom_range(0, 31);
                b = $urandom >> $urandom_range(0, 31);
            end
            else if (shape < 91)
            begin
                a = $urandom_range(0, 255);
                b = $urandom_range(0, 255);
            end
            else if (shape < 96)
            begin
                a = $urandom;
                b = a;
            end
            else
            begin
                a = ($urandom_range(0, 1) == 0) ? '0 : $urandom;
                b = (a == 0) ? $urandom : '0;
            end
            add_pair(a, b, (i % DRAIN_EVERY) == DRAIN_EVERY - 1);
        end

        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        fork
            begin
                do @(posedge clk); while (operand_pairs_q.size() != 0 || req_valid);
                do @(posedge clk); while (gcd_due_q.size() != 0);
                repeat (SETTLE_CYCLES) @(posedge clk);
            end
            begin
                wait (idle_cycles >= WATCHDOG_LIMIT);
                timed_out = 1'b1;
            end
        join_any

        if (!timed_out && mismatch_count == 0 && gcd_due_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
